// ===== src/heat_diffusion_mean_stencil_sweep_top_defines.svh =====
// Assertion macros for the checker file.
`ifndef HEAT_DIFFUSION_MEAN_STENCIL_SWEEP_TOP_DEFINES_SVH
`define HEAT_DIFFUSION_MEAN_STENCIL_SWEEP_TOP_DEFINES_SVH

// Check a property at every rising edge outside reset.
`define HDMS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property at every rising edge, reset included.
`define HDMS_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/hdms_pkg.sv =====
package hdms_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    localparam int COL_W      = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int ROW_W      = $clog2(MAX_HEIGHT + 2);
    localparam int CFG_DIM_W  = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam int VAL_W      = 24;
    localparam int ENTRY_W    = VAL_W + 1;
    localparam int LINE_W     = 2 * ENTRY_W;
    localparam int ROWSUM_W   = VAL_W + 2;
    localparam int SUM_W      = VAL_W + 4;
    localparam int CNT_W      = 4;
    localparam int RECIP_W    = 32;
    localparam int PROD_W     = SUM_W + RECIP_W;

    localparam logic [VAL_W-1:0] CLAMP_TOP = 24'hFF0000;

    localparam int OUT_DEPTH  = 8;
    localparam int OUT_PTR_W  = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W  = $clog2(OUT_DEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANGE_THRESHOLD = 2'd2;

    localparam logic CMD_CELL  = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    typedef struct packed {
        logic emit;
        logic last_cell;
        logic end_sweep;
        logic top_in;
        logic bot_in;
        logic left_in;
        logic right_in;
    } item_ctl_t;

    typedef struct packed {
        logic             sweep_changed;
        logic             last_cell;
        logic             cell_changed;
        logic [VAL_W-1:0] new_value;
    } result_t;

    function automatic logic [CFG_DIM_W-1:0] eff_dim(input logic [CFG_DIM_W-1:0] v,
                                                     input int max_v);
        logic [CFG_DIM_W-1:0] r;
        if (v == '0)
            r = CFG_DIM_W'(1);
        else if (v > max_v)
            r = CFG_DIM_W'(max_v);
        else
            r = v;
        return r;
    endfunction

    function automatic logic [CNT_W-1:0] cell_count(input item_ctl_t c);
        logic [1:0] rc;
        logic [1:0] cc;
        rc = 2'd1 + 2'(c.top_in) + 2'(c.bot_in);
        cc = 2'd1 + 2'(c.left_in) + 2'(c.right_in);
        return CNT_W'(rc) * CNT_W'(cc);
    endfunction

    // ceil(2^32 / n); exact quotient for sums below 2^28
    function automatic logic [RECIP_W-1:0] recip_of(input logic [CNT_W-1:0] n);
        logic [RECIP_W-1:0] r;
        unique case (n)
            4'd2:    r = 32'h8000_0000;
            4'd3:    r = 32'h5555_5556;
            4'd4:    r = 32'h4000_0000;
            4'd6:    r = 32'h2AAA_AAAB;
            4'd9:    r = 32'h1C71_C71D;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ===== src/heat_diffusion_mean_stencil_sweep_top.sv =====
// A result is pushed into the result buffer from stage s5, fed by the item that completes its
// neighbourhood, which is the item grid_width+1 places later in the stream.
// Throughput: 1 item per cycle; an 8-entry result buffer and an item credit count set
// tready, so it falls only once 8 items are in flight or waiting at the output.
// Reset: rst_n is asynchronous, active low; it clears counters, pipeline, buffer and sets
// grid_width 1024, grid_height 1024, change_threshold 1. Line memory is not cleared.
module heat_diffusion_mean_stencil_sweep_top
    import hdms_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [23:0]           s_axis_tdata,   // old_value
    input  logic [1:0]            s_axis_tuser,   // command, is_pinned

    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [23:0]           m_axis_tdata,   // new_value
    output logic [1:0]            m_axis_tuser,   // cell_changed, sweep_changed
    output logic                  m_axis_tlast
);

    logic [CFG_DIM_W-1:0] grid_width_reg;
    logic [CFG_DIM_W-1:0] grid_height_reg;
    logic [VAL_W-1:0]     threshold_reg;

    logic [COL_W-1:0]     col_reg;
    logic [COL_W-1:0]     col_next;
    logic [ROW_W-1:0]     row_reg;
    logic [ROW_W-1:0]     row_next;

    logic [LINE_W-1:0]    line_mem [MAX_WIDTH];
    logic [LINE_W-1:0]    line_rd_reg;
    logic [LINE_W-1:0]    fwd_data_reg;
    logic                 s1_fwd_reg;
    logic [LINE_W-1:0]    line_wdata;
    logic [ENTRY_W-1:0]   upper_in;
    logic [ENTRY_W-1:0]   middle_in;

    logic [ENTRY_W-1:0]   win_reg [3][3];

    logic                 s1_valid_reg;
    logic                 s2_valid_reg;
    logic                 s3_valid_reg;
    logic                 s4_valid_reg;
    logic                 s5_valid_reg;
    item_ctl_t            s1_ctl_reg;
    item_ctl_t            s2_ctl_reg;
    item_ctl_t            s3_ctl_reg;
    item_ctl_t            s4_ctl_reg;
    item_ctl_t            s5_ctl_reg;
    logic [ENTRY_W-1:0]   s1_entry_reg;
    logic [COL_W-1:0]     s1_col_reg;

    logic [ROWSUM_W-1:0]  row_sum [3];
    logic [ROWSUM_W-1:0]  s3_rsum_reg [3];
    logic [ENTRY_W-1:0]   s3_centre_reg;
    logic [SUM_W-1:0]     s4_total_reg;
    logic [CNT_W-1:0]     s4_cnt_reg;
    logic [ENTRY_W-1:0]   s4_centre_reg;
    logic [PROD_W-1:0]    s5_prod_reg;
    logic [SUM_W-1:0]     s5_total_reg;
    logic                 s5_one_reg;
    logic [ENTRY_W-1:0]   s5_centre_reg;

    logic                 any_change_reg;
    logic                 any_change_next;

    result_t              out_buf_reg [OUT_DEPTH];
    logic [OUT_PTR_W-1:0] wr_ptr_reg;
    logic [OUT_PTR_W-1:0] rd_ptr_reg;
    logic [OUT_CNT_W-1:0] out_cnt_reg;
    logic [OUT_CNT_W-1:0] out_cnt_next;
    logic [OUT_CNT_W-1:0] credit_reg;
    logic [OUT_CNT_W-1:0] credit_next;

    logic                 accept;
    logic                 push;
    logic                 pop;
    logic                 drop;
    logic [CFG_DIM_W-1:0] w_eff;
    logic [CFG_DIM_W-1:0] h_eff;
    logic [ROW_W:0]       orow;
    logic [ROW_W-1:0]     orow_u;
    logic                 orow_neg;
    logic [CFG_DIM_W-1:0] ocol;
    logic                 row_wrap;
    item_ctl_t            ctl_in;
    logic [ENTRY_W-1:0]   entry_in;

    logic [SUM_W-1:0]     quot;
    logic [VAL_W-1:0]     mean_val;
    logic [VAL_W-1:0]     old_val;
    logic [VAL_W-1:0]     diff;
    logic                 changed;
    result_t              result;

    // ---------------------------------------------------------------- input side
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (credit_reg < OUT_CNT_W'(OUT_DEPTH));

    assign w_eff = eff_dim(grid_width_reg, MAX_WIDTH);
    assign h_eff = eff_dim(grid_height_reg, MAX_HEIGHT);

    assign entry_in = (s_axis_tuser[0] == CMD_CELL) ? {s_axis_tuser[1], s_axis_tdata} : '0;

    always_comb
    begin
        if (col_reg == '0)
        begin
            orow = {1'b0, row_reg} - (ROW_W+1)'(2);
            ocol = w_eff - CFG_DIM_W'(1);
        end
        else
        begin
            orow = {1'b0, row_reg} - (ROW_W+1)'(1);
            ocol = CFG_DIM_W'(col_reg) - CFG_DIM_W'(1);
        end
        orow_neg = orow[ROW_W];
        orow_u   = orow[ROW_W-1:0];

        ctl_in.emit      = !orow_neg && (orow_u < h_eff) && (ocol < w_eff);
        ctl_in.last_cell = (orow_u == ROW_W'(h_eff - CFG_DIM_W'(1))) &&
                           (ocol == w_eff - CFG_DIM_W'(1));
        ctl_in.end_sweep = (ctl_in.emit && ctl_in.last_cell) || (!orow_neg && orow_u >= h_eff);
        ctl_in.top_in    = (orow_u != '0);
        ctl_in.bot_in    = (orow_u < ROW_W'(h_eff - CFG_DIM_W'(1)));
        ctl_in.left_in   = (ocol != '0);
        ctl_in.right_in  = (ocol < w_eff - CFG_DIM_W'(1));

        row_wrap = ((CFG_DIM_W'(col_reg) + CFG_DIM_W'(1)) >= w_eff);
        if (ctl_in.end_sweep)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (row_wrap)
        begin
            col_next = '0;
            row_next = row_reg + ROW_W'(1);
        end
        else
        begin
            col_next = col_reg + COL_W'(1);
            row_next = row_reg;
        end
    end

    // ---------------------------------------------------------------- line memory
    // forward the entry written in the same cycle as this item's read
    assign upper_in   = s1_fwd_reg ? fwd_data_reg[LINE_W-1:ENTRY_W] : line_rd_reg[LINE_W-1:ENTRY_W];
    assign middle_in  = s1_fwd_reg ? fwd_data_reg[ENTRY_W-1:0]      : line_rd_reg[ENTRY_W-1:0];
    assign line_wdata = {middle_in, s1_entry_reg};

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
            line_mem[s1_col_reg] <= line_wdata;
        if (accept)
            line_rd_reg <= line_mem[col_reg];
    end

    // ---------------------------------------------------------------- neighbourhood sums
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            row_sum[r] = (s2_ctl_reg.left_in ? ROWSUM_W'(win_reg[r][0][VAL_W-1:0]) : '0) +
                         ROWSUM_W'(win_reg[r][1][VAL_W-1:0]) +
                         (s2_ctl_reg.right_in ? ROWSUM_W'(win_reg[r][2][VAL_W-1:0]) : '0);
        end
        if (!s2_ctl_reg.top_in)
            row_sum[0] = '0;
        if (!s2_ctl_reg.bot_in)
            row_sum[2] = '0;
    end

    // ---------------------------------------------------------------- final stage
    always_comb
    begin
        old_val  = s5_centre_reg[VAL_W-1:0];
        quot     = s5_one_reg ? s5_total_reg : s5_prod_reg[PROD_W-1:RECIP_W];
        mean_val = (quot > SUM_W'(CLAMP_TOP)) ? CLAMP_TOP : quot[VAL_W-1:0];
        diff     = (mean_val >= old_val) ? (mean_val - old_val) : (old_val - mean_val);
        changed  = !s5_centre_reg[VAL_W] && (diff >= threshold_reg);

        any_change_next = any_change_reg;
        if (s5_valid_reg && s5_ctl_reg.emit && changed)
            any_change_next = 1'b1;

        result.new_value     = s5_centre_reg[VAL_W] ? old_val : mean_val;
        result.cell_changed  = changed;
        result.last_cell     = s5_ctl_reg.last_cell;
        result.sweep_changed = s5_ctl_reg.last_cell && any_change_next;
    end

    assign push = s5_valid_reg && s5_ctl_reg.emit;
    assign drop = s5_valid_reg && !s5_ctl_reg.emit;
    assign pop  = m_axis_tvalid && m_axis_tready;

    assign out_cnt_next = out_cnt_reg + OUT_CNT_W'(push) - OUT_CNT_W'(pop);
    assign credit_next  = credit_reg + OUT_CNT_W'(accept) - OUT_CNT_W'(pop) - OUT_CNT_W'(drop);

    assign m_axis_tvalid = (out_cnt_reg != '0);
    assign m_axis_tdata  = out_buf_reg[rd_ptr_reg].new_value;
    assign m_axis_tuser  = {out_buf_reg[rd_ptr_reg].sweep_changed,
                            out_buf_reg[rd_ptr_reg].cell_changed};
    assign m_axis_tlast  = out_buf_reg[rd_ptr_reg].last_cell;

    // ---------------------------------------------------------------- control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= CFG_DIM_W'(1024);
            grid_height_reg <= CFG_DIM_W'(1024);
            threshold_reg   <= VAL_W'(1);
            col_reg         <= '0;
            row_reg         <= '0;
            s1_valid_reg    <= 1'b0;
            s2_valid_reg    <= 1'b0;
            s3_valid_reg    <= 1'b0;
            s4_valid_reg    <= 1'b0;
            s5_valid_reg    <= 1'b0;
            any_change_reg  <= 1'b0;
            wr_ptr_reg      <= '0;
            rd_ptr_reg      <= '0;
            out_cnt_reg     <= '0;
            credit_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_GRID_WIDTH:       grid_width_reg  <= cfg_data[CFG_DIM_W-1:0];
                    CFG_GRID_HEIGHT:      grid_height_reg <= cfg_data[CFG_DIM_W-1:0];
                    CFG_CHANGE_THRESHOLD: threshold_reg   <= cfg_data[VAL_W-1:0];
                    default:              ;
                endcase
            end
            if (accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;

            if (s5_valid_reg && s5_ctl_reg.end_sweep)
                any_change_reg <= 1'b0;
            else
                any_change_reg <= any_change_next;

            if (push)
                wr_ptr_reg <= wr_ptr_reg + OUT_PTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + OUT_PTR_W'(1);
            out_cnt_reg <= out_cnt_next;
            credit_reg  <= credit_next;
        end
    end

    // ---------------------------------------------------------------- datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_ctl_reg   <= ctl_in;
            s1_entry_reg <= entry_in;
            s1_col_reg   <= col_reg;
            s1_fwd_reg   <= s1_valid_reg && (s1_col_reg == col_reg);
            fwd_data_reg <= line_wdata;
        end

        if (s1_valid_reg)
        begin
            for (int r = 0; r < 3; r++)
            begin
                win_reg[r][0] <= win_reg[r][1];
                win_reg[r][1] <= win_reg[r][2];
            end
            win_reg[0][2] <= upper_in;
            win_reg[1][2] <= middle_in;
            win_reg[2][2] <= s1_entry_reg;
            s2_ctl_reg    <= s1_ctl_reg;
        end

        if (s2_valid_reg)
        begin
            s3_rsum_reg   <= row_sum;
            s3_centre_reg <= win_reg[1][1];
            s3_ctl_reg    <= s2_ctl_reg;
        end

        if (s3_valid_reg)
        begin
            s4_total_reg  <= SUM_W'(s3_rsum_reg[0]) + SUM_W'(s3_rsum_reg[1]) +
                             SUM_W'(s3_rsum_reg[2]);
            s4_cnt_reg    <= cell_count(s3_ctl_reg);
            s4_centre_reg <= s3_centre_reg;
            s4_ctl_reg    <= s3_ctl_reg;
        end

        if (s4_valid_reg)
        begin
            s5_prod_reg   <= PROD_W'(s4_total_reg) * PROD_W'(recip_of(s4_cnt_reg));
            s5_total_reg  <= s4_total_reg;
            s5_one_reg    <= (s4_cnt_reg == CNT_W'(1));
            s5_centre_reg <= s4_centre_reg;
            s5_ctl_reg    <= s4_ctl_reg;
        end

        if (push)
            out_buf_reg[wr_ptr_reg] <= result;
    end

endmodule

// ===== src/hdms_checker.sv =====
`include "heat_diffusion_mean_stencil_sweep_top_defines.svh"

module hdms_checker
    import hdms_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,   // new_value
    input logic [1:0]  m_axis_tuser,   // cell_changed, sweep_changed
    input logic        m_axis_tlast
);

    logic [VAL_W-1:0] out_value;

    assign out_value = m_axis_tdata[VAL_W-1:0];

    `HDMS_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "item dropped while stalled")
    `HDMS_ASSERT(a_out_stable, m_axis_tvalid && !m_axis_tready |=> $stable(out_value) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "item changed while stalled")
    `HDMS_ASSERT(a_sweep_on_last, m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tlast, "sweep flag off the last item")
    `HDMS_ASSERT(a_last_change_seen, m_axis_tvalid && m_axis_tlast && m_axis_tuser[0] |-> m_axis_tuser[1], "last item changed but sweep flag clear")
    `HDMS_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !m_axis_tvalid, "output valid straight after reset")

endmodule

bind heat_diffusion_mean_stencil_sweep_top hdms_checker u_hdms_checker (.*);
